/* hw/rtl/gear_ratio_detector_defines.svh */
// Assertion macros for the gear ratio detector RTL.
// Needs clk and rst_n in the scope that uses them; no other dependencies.
`ifndef GEAR_RATIO_DETECTOR_DEFINES_SVH
`define GEAR_RATIO_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset
`define GRD_ASSERT_COMB(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequence that must hold on the cycle after the trigger
`define GRD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define GRD_ASSERT_COMB(lbl, expr)
`define GRD_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* hw/rtl/grd_pkg.sv */
// Shared types and constants for the gear ratio detector.
// No dependencies; imported by grd_divider, grd_filter, the top level and the testbench.
`default_nettype none

package grd_pkg;

  localparam int MOTOR_W     = 15;
  localparam int WHEEL_W     = 16;
  localparam int RAW_W       = 15;
  localparam int GEAR_W      = 8;
  localparam int TABLE_W     = 64;
  localparam int TABLE_IDX_W = 3;

  localparam logic [GEAR_W:0] LOWER_BOUND_MIN = 9'd1;
  localparam logic [GEAR_W:0] UPPER_BOUND_MAX = 9'd10;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_SCAN,
    BE_DONE
  } be_state_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear;
    logic              agrees;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/grd_fifo.sv */
// Small first-word-first-out queue of registers, parameterised in width and depth.
// Depends on the assertion macros header only.
`default_nettype none
`include "gear_ratio_detector_defines.svh"

module grd_fifo #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `GRD_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

`default_nettype wire

/* hw/rtl/grd_divider.sv */
// Front part: accepts input words and forms the raw ratio with a radix-2 divider.
// Depends on grd_pkg and the assertion macros header.
`default_nettype none
`include "gear_ratio_detector_defines.svh"

module grd_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [grd_pkg::MOTOR_W-1:0] in_motor_speed,
  input  logic signed [grd_pkg::WHEEL_W-1:0] in_wheel_rpm,
  output logic                        q_push,
  input  logic                        q_full,
  output logic [grd_pkg::RAW_W-1:0]   q_raw
);

  import grd_pkg::*;

  localparam int CNT_W = $clog2(RAW_W);

  fe_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RAW_W-1:0] quo_r, quo_nxt;
  logic [RAW_W-1:0] rem_r, rem_nxt;
  logic [RAW_W-1:0] div_r, div_nxt;
  logic             accept;
  logic             wheel_pos;
  logic [RAW_W:0]   rem_sh;
  logic [RAW_W:0]   diff;
  logic             q_bit;

  assign accept    = in_push && !in_full;
  // positive: sign bit clear and nonzero
  assign wheel_pos = !in_wheel_rpm[WHEEL_W-1] && (in_wheel_rpm != '0);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem_r, quo_r[RAW_W-1]};
  assign diff   = rem_sh - {1'b0, div_r};
  assign q_bit  = (rem_sh >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (accept) state_nxt = wheel_pos ? FE_DIV : FE_PUSH;
      FE_DIV:  if (cnt_r == '0) state_nxt = FE_PUSH;
      FE_PUSH: if (!q_full) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_full = 1'b1;
    q_push  = 1'b0;
    unique case (state_r)
      FE_IDLE: in_full = 1'b0;
      FE_DIV:  in_full = 1'b1;
      FE_PUSH: q_push  = !q_full;
      default: in_full = 1'b1;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (state_r == FE_IDLE && accept) begin
      cnt_nxt = CNT_W'(RAW_W - 1);
      rem_nxt = '0;
      div_nxt = in_wheel_rpm[RAW_W-1:0];
      quo_nxt = wheel_pos ? in_motor_speed : '0;
    end else if (state_r == FE_DIV) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      rem_nxt = q_bit ? diff[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      quo_nxt = {quo_r[RAW_W-2:0], q_bit};
    end
  end

  assign q_raw = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  `GRD_ASSERT_NEXT(a_div_start, state_r == FE_IDLE && accept && wheel_pos,
                   state_r == FE_DIV && rem_r == '0)

endmodule

`default_nettype wire

/* hw/rtl/grd_filter.sv */
// Back part: walks the gear windows one gear a cycle, fills the history ring
// and issues the filtered gear. Depends on grd_pkg and the assertion macros header.
`default_nettype none
`include "gear_ratio_detector_defines.svh"

module grd_filter #(
  parameter int GEAR_COUNT    = 8,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [grd_pkg::TABLE_W-1:0] cfg_gear_table,
  input  logic                        raw_empty,
  output logic                        raw_pop,
  input  logic [grd_pkg::RAW_W-1:0]   raw_data,
  input  logic                        res_full,
  output logic                        res_push,
  output grd_pkg::res_t               res_data
);

  import grd_pkg::*;

  localparam int IDX_W = $clog2(GEAR_COUNT);
  localparam int POS_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GEAR_COUNT - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);

  be_state_t          state_r, state_nxt;
  logic [TABLE_W-1:0] table_r;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [GEAR_W-1:0]  hist_r   [HISTORY_DEPTH];
  logic [GEAR_W-1:0]  hist_nxt [HISTORY_DEPTH];
  logic [GEAR_W-1:0]  sel_r, sel_nxt;

  logic [TABLE_IDX_W-1:0] idx3, prv3, nxt3;
  logic [GEAR_W-1:0]      cur, prv, nxt;
  logic [GEAR_W:0]        lo_sum, hi_sum;
  logic [GEAR_W:0]        lo, hi;
  logic                   hit;
  logic                   same;

  assign cfg_ready = 1'b1;

  // window of the gear under scan
  assign idx3   = TABLE_IDX_W'(idx_r);
  assign prv3   = idx3 - TABLE_IDX_W'(1);
  assign nxt3   = idx3 + TABLE_IDX_W'(1);
  assign cur    = table_r[{idx3, 3'b000} +: GEAR_W];
  assign prv    = table_r[{prv3, 3'b000} +: GEAR_W];
  assign nxt    = table_r[{nxt3, 3'b000} +: GEAR_W];
  assign lo_sum = {1'b0, cur} + {1'b0, prv};
  assign hi_sum = {1'b0, cur} + {1'b0, nxt};
  assign lo     = (idx_r == '0) ? LOWER_BOUND_MIN : {1'b0, lo_sum[GEAR_W:1]};
  assign hi     = (idx_r == LAST_IDX) ? ({1'b0, cur} + UPPER_BOUND_MAX)
                                      : {1'b0, hi_sum[GEAR_W:1]};
  assign hit    = (raw_r >= RAW_W'(lo)) && (raw_r <= RAW_W'(hi));

  always_comb begin
    same = 1'b1;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      if (hist_r[k] != hist_r[0]) same = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_IDLE: if (!raw_empty) state_nxt = BE_SCAN;
      BE_SCAN: if (idx_r == LAST_IDX) state_nxt = BE_DONE;
      BE_DONE: if (!res_full) state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_comb begin
    raw_pop  = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      BE_IDLE: raw_pop  = !raw_empty;
      BE_SCAN: raw_pop  = 1'b0;
      BE_DONE: res_push = !res_full;
      default: raw_pop  = 1'b0;
    endcase
  end

  always_comb begin
    raw_nxt = raw_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    sel_nxt = sel_r;
    for (int k = 0; k < HISTORY_DEPTH; k++) hist_nxt[k] = hist_r[k];
    if (state_r == BE_IDLE && !raw_empty) begin
      raw_nxt = raw_data;
      idx_nxt = '0;
    end else if (state_r == BE_SCAN) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (hit) begin
        // a tie on a midpoint hits twice, on consecutive gears
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          if (pos_r == POS_W'(k)) hist_nxt[k] = cur;
        end
        pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + POS_W'(1);
      end
    end else if (state_r == BE_DONE && !res_full && same) begin
      sel_nxt = hist_r[0];
    end
  end

  assign res_data.gear   = same ? hist_r[0] : sel_r;
  assign res_data.agrees = same;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
      table_r <= '0;
      idx_r   <= '0;
      pos_r   <= '0;
      sel_r   <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) table_r <= cfg_gear_table;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
      sel_r   <= sel_nxt;
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_r[k] <= hist_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  `GRD_ASSERT_COMB(a_pos_range, {1'b0, pos_r} < (POS_W + 1)'(HISTORY_DEPTH))
  `GRD_ASSERT_NEXT(a_scan_end, state_r == BE_SCAN && idx_r == LAST_IDX, state_r == BE_DONE)

endmodule

`default_nettype wire

/* hw/rtl/gear_ratio_detector.sv */
// Top level of the gear ratio detector: divider front, gear filter back, a queue between
// them and one at the output. Depends on grd_pkg, grd_fifo, grd_divider, grd_filter.
//
//   channel  direction  handshake          payload
//   in_      input      in_push / in_full  in_motor_speed[14:0], in_wheel_rpm[15:0]
//   out_     output     out_pop / out_empty out_current_gear[7:0], out_filter_agrees
//   cfg_     input      cfg_valid/cfg_ready cfg_gear_table[63:0]
//
// Flow: the front accepts a word, divides it in 15 radix-2 steps if the wheel speed is
// positive, then hands it off; the back scans GEAR_COUNT windows and issues the result,
// one gear window a cycle, overlapped with the next divide; the slower one sets the rate.
// Reset: synchronous, active low rst_n clears table, history, selected gear and queues.
// Stalls: in_full rises while the divider is busy or cannot hand on its word;
// a full result queue holds the back, a full raw queue holds the front.
`default_nettype none

module gear_ratio_detector #(
  parameter int GEAR_COUNT    = 8,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [grd_pkg::MOTOR_W-1:0] in_motor_speed,
  input  logic signed [grd_pkg::WHEEL_W-1:0] in_wheel_rpm,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [grd_pkg::GEAR_W-1:0]  out_current_gear,
  output logic                        out_filter_agrees,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [grd_pkg::TABLE_W-1:0] cfg_gear_table
);

  import grd_pkg::*;

  // raw ratio queue between front and back
  logic             raw_push;
  logic             raw_full;
  logic [RAW_W-1:0] raw_wdata;
  logic             raw_pop;
  logic             raw_empty;
  logic [RAW_W-1:0] raw_rdata;

  // result queue towards the output side
  logic             res_push;
  logic             res_full;
  res_t             res_wdata;
  res_t             res_rdata;

  // front: accept a word and divide
  grd_divider u_divider (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_motor_speed (in_motor_speed),
    .in_wheel_rpm   (in_wheel_rpm),
    .q_push         (raw_push),
    .q_full         (raw_full),
    .q_raw          (raw_wdata)
  );

  // decouple the divider from the gear scan
  grd_fifo #(
    .WIDTH (RAW_W),
    .DEPTH (2)
  ) u_raw_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (raw_push),
    .full  (raw_full),
    .wdata (raw_wdata),
    .pop   (raw_pop),
    .empty (raw_empty),
    .rdata (raw_rdata)
  );

  // back: scan the gear windows, update history, issue the result
  grd_filter #(
    .GEAR_COUNT    (GEAR_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_filter (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_gear_table (cfg_gear_table),
    .raw_empty      (raw_empty),
    .raw_pop        (raw_pop),
    .raw_data       (raw_rdata),
    .res_full       (res_full),
    .res_push       (res_push),
    .res_data       (res_wdata)
  );

  // hold finished results until the consumer pops them
  grd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_wdata),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_rdata)
  );

  assign out_current_gear  = res_rdata.gear;
  assign out_filter_agrees = res_rdata.agrees;

endmodule

`default_nettype wire

/* tb/gear_ratio_detector_test.sv */
// Self-checking testbench for gear_ratio_detector: random and directed words,
// a scoreboard class that predicts the gear filter, and checks on every result.
// Depends on grd_pkg and the gear_ratio_detector RTL only.
`default_nettype none

module gear_ratio_detector_test;
  import grd_pkg::*;

  localparam int GEAR_COUNT      = 8;
  localparam int HISTORY_DEPTH   = 4;
  localparam int WORDS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RUN_LIMIT       = 8_000_000;

  // Predicts the selected gear for each accepted word and holds the results
  // still owed by the block, oldest first.
  class gear_result_book;
    logic [TABLE_W-1:0] ratios;
    logic [GEAR_W-1:0]  history[HISTORY_DEPTH];
    int unsigned        wr_pos;
    logic [GEAR_W-1:0]  selected;
    res_t               pending[$];
    int unsigned        words, checked, agreed, failures;

    function new();
      ratios   = '0;
      wr_pos   = 0;
      selected = '0;
      foreach (history[i]) history[i] = '0;
      words    = 0;
      checked  = 0;
      agreed   = 0;
      failures = 0;
    endfunction

    function void set_table(logic [TABLE_W-1:0] value);
      ratios = value;
    endfunction

    function int unsigned entry(int g);
      return int'(ratios[g*8 +: 8]);
    endfunction

    // Window bounds of one gear; the outer gears use the fixed limits.
    function void window(int g, output int unsigned lo, output int unsigned hi);
      if (g == 0) begin
        lo = int'(LOWER_BOUND_MIN);
        hi = (entry(0) + entry(1)) / 2;
      end else if (g == GEAR_COUNT - 1) begin
        lo = (entry(g) + entry(g - 1)) / 2;
        hi = entry(g) + int'(UPPER_BOUND_MAX);
      end else begin
        lo = (entry(g) + entry(g - 1)) / 2;
        hi = (entry(g) + entry(g + 1)) / 2;
      end
    endfunction

    function void note_word(logic [MOTOR_W-1:0] motor, logic signed [WHEEL_W-1:0] wheel);
      int unsigned raw, lo, hi;
      bit          same;
      res_t        r;
      raw = 0;
      if (wheel > 0) raw = int'(motor) / int'(wheel);
      // Every matching window writes its gear, lowest gear first.
      for (int g = 0; g < GEAR_COUNT; g++) begin
        window(g, lo, hi);
        if (raw >= lo && raw <= hi) begin
          history[wr_pos] = ratios[g*8 +: 8];
          wr_pos = (wr_pos + 1) % HISTORY_DEPTH;
        end
      end
      same = 1'b1;
      for (int i = 1; i < HISTORY_DEPTH; i++)
        if (history[i] != history[0]) same = 1'b0;
      if (same) begin
        selected = history[0];
        agreed++;
      end
      r.gear   = selected;
      r.agrees = same;
      pending.push_back(r);
      words++;
    endfunction

    function void check_word(logic [GEAR_W-1:0] gear, logic agrees);
      res_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no word outstanding: current_gear %0d, filter_agrees %0d",
               gear, agrees);
        failures++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (gear !== exp_r.gear) begin
        $error("current_gear: expected %0d, got %0d", exp_r.gear, gear);
        failures++;
      end
      if (agrees !== exp_r.agrees) begin
        $error("filter_agrees: expected %0d, got %0d", exp_r.agrees, agrees);
        failures++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_push;
  logic                       in_full;
  logic [MOTOR_W-1:0]         in_motor_speed;
  logic signed [WHEEL_W-1:0]  in_wheel_rpm;
  logic                       out_empty;
  logic                       out_pop;
  logic [GEAR_W-1:0]          out_current_gear;
  logic                       out_filter_agrees;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [TABLE_W-1:0]         cfg_gear_table;

  gear_result_book gear_book;
  bit              tx_steady;
  int unsigned     n_tables;

  gear_ratio_detector #(
    .GEAR_COUNT    (GEAR_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_motor_speed    (in_motor_speed),
    .in_wheel_rpm      (in_wheel_rpm),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_current_gear  (out_current_gear),
    .out_filter_agrees (out_filter_agrees),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_gear_table    (cfg_gear_table)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one word after a random gap and hold it until the block takes it.
  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic send_word(input logic [MOTOR_W-1:0] motor,
                           input logic signed [WHEEL_W-1:0] wheel);
    int gap;
    // Flip between steady streaming and ragged gaps now and then.
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_motor_speed <= motor;
    in_wheel_rpm   <= wheel;
    do @(posedge clk); while (in_full);
    gear_book.note_word(motor, wheel);
  endtask

  // Hold the sender until every owed result has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    while (gear_book.pending.size() != 0) @(posedge clk);
  endtask

  // Load a new gear table; only called with the block idle.
  task automatic write_table(input logic [TABLE_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_gear_table <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gear_book.set_table(value);
    n_tables++;
  endtask

  // Result side: pop with its own random stalls and check each word taken.
  initial begin : result_sink
    int  gap;
    bit  rx_steady;
    rx_steady = 1'b0;
    out_pop   = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      gear_book.check_word(out_current_gear, out_filter_agrees);
    end
  end

  initial begin : stimulus
    logic [TABLE_W-1:0]        ratios;
    logic [MOTOR_W-1:0]        m;
    logic signed [WHEEL_W-1:0] w;
    int unsigned               lo, hi, raw, wmax, step_up;
    int                        g, burst, n;
    bit                        paused;

    gear_book      = new();
    tx_steady      = 1'b0;
    n_tables       = 0;
    paused         = 1'b0;
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_motor_speed = '0;
    in_wheel_rpm   = '0;
    cfg_valid      = 1'b0;
    cfg_gear_table = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset table (all ratios zero): a zero, negative
    // and most negative wheel speed, the largest ratio, and a ratio that only
    // the top gear's window can hold.
    send_word(15'd0, 16'sd0);
    send_word(15'd32767, -16'sd1);
    send_word(15'd0, -16'sd32768);
    send_word(15'd32767, 16'sd1);
    send_word(15'd5, 16'sd1);
    send_word(15'd21845, 16'sd32767);

    // Sorted table 10, 20, 30, 40, 60, 80, 100, 150.
    drain_results();
    write_table(64'h9664_503C_281E_140A);
    send_word(15'd15, 16'sd1);        // tie on the midpoint of the two lowest gears
    send_word(15'd150, 16'sd10);      // same tie reached through the divider
    send_word(15'd1, 16'sd1);         // lowest gear's floor
    send_word(15'd0, 16'sd1);         // raw ratio zero, no window
    send_word(15'd160, 16'sd1);       // top gear's ceiling
    send_word(15'd161, 16'sd1);       // just past it
    repeat (4) send_word(15'd400, 16'sd10);  // fill the ring with one gear
    send_word(15'd32767, 16'sd32767);
    send_word(15'd32767, 16'sd16384);
    send_word(15'd25, 16'sd1);        // tie between the second and third gears
    send_word(15'd9, 16'sd1);

    // Random phases, one gear table each: sorted, all ones, all zeros,
    // unsorted, sorted random, runs of zero entries, and tightly packed.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ratios = 64'h9664_503C_281E_140A;
        1: ratios = '1;
        2: ratios = '0;
        3: ratios = {$urandom, $urandom};
        4: begin
          step_up = 0;
          for (int k = 0; k < GEAR_COUNT; k++) begin
            step_up += $urandom_range(1, 31);
            ratios[k*8 +: 8] = step_up[7:0];
          end
        end
        5: ratios = {$urandom, $urandom} & 64'hFFFF_FF00_0000_FFFF;
        default: ratios = 64'h0807_0605_0403_0201;
      endcase
      drain_results();
      write_table(ratios);

      n = 0;
      while (n < WORDS_PER_PHASE) begin
        // Once mid-run, starve the block until it has handed back everything.
        if (ph == 3 && !paused && n >= WORDS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          // Burst aimed at one gear's window, so the ring can settle on it.
          g = $urandom_range(0, GEAR_COUNT - 1);
          gear_book.window(g, lo, hi);
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++) begin
            raw = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 270);
            if (raw == 0) begin
              // Reach a zero ratio by a nonpositive wheel or by motor < wheel.
              if ($urandom_range(0, 1) != 0) begin
                w = WHEEL_W'(-int'($urandom_range(0, 32768)));
                m = MOTOR_W'($urandom);
              end else begin
                w = WHEEL_W'($urandom_range(1, 32767));
                m = MOTOR_W'($urandom_range(0, int'(w) - 1));
              end
            end else begin
              wmax = 32767 / (raw + 1);
              if ($urandom_range(0, 1) != 0 && wmax > 8) wmax = 8;
              w = WHEEL_W'($urandom_range(1, wmax));
              m = MOTOR_W'(raw * int'(w) + $urandom_range(0, int'(w) - 1));
            end
            send_word(m, w);
            n++;
          end
        end else begin
          // Noise: any motor speed, any wheel speed.
          send_word(MOTOR_W'($urandom), WHEEL_W'($urandom));
          n++;
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d words over %0d gear tables; %0d results checked,",
             gear_book.words, n_tables, gear_book.checked);
    $display("%0d of them with the history ring in agreement.", gear_book.agreed);
    if (gear_book.failures == 0 && gear_book.pending.size() == 0)
      $display("gear_ratio_detector test passed");
    else
      $display("gear_ratio_detector test failed");
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("gear_ratio_detector test failed");
    $finish;
  end

endmodule

`default_nettype wire
